// ----- rtl/mr_pkg.sv -----
// Shared constants, command codes and interface structs for the Miller-Rabin round.
`timescale 1ns / 1ps
`default_nettype none
package mr_pkg;

  localparam int NUM_BITS  = 64;
  localparam int RND_W     = 32;
  localparam int DIV_CNT_W = $clog2(RND_W);

  localparam logic [NUM_BITS-1:0] WORD_ONE = {{(NUM_BITS-1){1'b0}}, 1'b1};
  localparam logic [NUM_BITS-1:0] WORD_TWO = {{(NUM_BITS-2){1'b0}}, 2'b10};
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(RND_W - 1);

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // capture word, p-1, reset divider
    CMD_ODD_STEP,  // s >>= 1
    CMD_DIV_STEP,  // one restoring step of random mod (p-1)
    CMD_WIT,       // witness = rem + 1, start exponentiation
    CMD_MUL_RES,   // start res * base
    CMD_MUL_BASE,  // start base * base
    CMD_MUL_SQ,    // start x * x
    CMD_MUL_STEP,  // one shift-and-add step
    CMD_RES_WB,    // res = product
    CMD_BASE_WB,   // base = product, exponent copy >>= 1
    CMD_SQ_WB      // x = product, e <<= 1
  } mr_cmd_e;

  typedef struct packed {
    mr_cmd_e cmd;
  } mr_ctrl_t;

  typedef struct packed {
    logic reject;
    logic s_odd;
    logic div_last;
    logic sh_zero;
    logic sh_lsb;
    logic mul_done;
    logic loop_exit;
    logic pass;
  } mr_stat_t;

endpackage
`default_nettype wire

// ----- rtl/mr_datapath.sv -----
// Datapath: operand registers, restoring divider step and bit-serial modular multiplier.
`timescale 1ns / 1ps
`default_nettype none
module mr_datapath (
  input  wire logic                          clk_i,
  input  wire logic [mr_pkg::NUM_BITS-1:0]   cand_i,
  input  wire logic [mr_pkg::RND_W-1:0]      rnd_i,
  input  wire mr_pkg::mr_ctrl_t              ctrl_i,
  output      mr_pkg::mr_stat_t              stat_o
);
  import mr_pkg::*;

  logic [NUM_BITS-1:0]  p_q, p_d, pm1_q, pm1_d, s_q, s_d;
  logic [NUM_BITS-1:0]  e_q, e_d, sh_q, sh_d, base_q, base_d, x_q, x_d;
  logic [NUM_BITS-1:0]  rem_q, rem_d, ma_q, ma_d, mb_q, mb_d, acc_q, acc_d;
  logic [RND_W-1:0]     rnd_q, rnd_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_BITS-1:0]  trial, sum, dbl;

  always_comb begin
    trial = {rem_q[NUM_BITS-2:0], rnd_q[RND_W-1]};
    sum   = acc_q + ma_q;
    dbl   = {ma_q[NUM_BITS-2:0], 1'b0};
    p_d = p_q; pm1_d = pm1_q; s_d = s_q; e_d = e_q; sh_d = sh_q;
    base_d = base_q; x_d = x_q; rem_d = rem_q; ma_d = ma_q; mb_d = mb_q;
    acc_d = acc_q; rnd_d = rnd_q; cnt_d = cnt_q;
    unique case (ctrl_i.cmd)
      CMD_LOAD: begin
        p_d   = cand_i;
        pm1_d = cand_i - WORD_ONE;
        s_d   = cand_i - WORD_ONE;
        rnd_d = rnd_i;
        rem_d = '0;
        cnt_d = '0;
      end
      CMD_ODD_STEP: s_d = s_q >> 1;
      CMD_DIV_STEP: begin
        rem_d = (trial >= pm1_q) ? trial - pm1_q : trial;
        rnd_d = rnd_q << 1;
        cnt_d = cnt_q + DIV_CNT_W'(1);
      end
      CMD_WIT: begin
        base_d = rem_q + WORD_ONE;
        x_d    = WORD_ONE;
        sh_d   = s_q;
        e_d    = s_q;
      end
      CMD_MUL_RES: begin
        ma_d = x_q; mb_d = base_q; acc_d = '0;
      end
      CMD_MUL_BASE: begin
        ma_d = base_q; mb_d = base_q; acc_d = '0;
      end
      CMD_MUL_SQ: begin
        ma_d = x_q; mb_d = x_q; acc_d = '0;
      end
      CMD_MUL_STEP: begin
        if (mb_q[0]) begin
          acc_d = (sum >= p_q) ? sum - p_q : sum;
        end
        ma_d = (dbl >= p_q) ? dbl - p_q : dbl;
        mb_d = mb_q >> 1;
      end
      CMD_RES_WB: x_d = acc_q;
      CMD_BASE_WB: begin
        base_d = acc_q;
        sh_d   = sh_q >> 1;
      end
      CMD_SQ_WB: begin
        x_d = acc_q;
        e_d = e_q << 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; pm1_q <= pm1_d; s_q <= s_d; e_q <= e_d; sh_q <= sh_d;
    base_q <= base_d; x_q <= x_d; rem_q <= rem_d; ma_q <= ma_d; mb_q <= mb_d;
    acc_q <= acc_d; rnd_q <= rnd_d; cnt_q <= cnt_d;
  end

  always_comb begin
    stat_o.reject    = p_q[NUM_BITS-1] || (p_q < WORD_TWO) ||
                       (!p_q[0] && (p_q != WORD_TWO));
    stat_o.s_odd     = s_q[0];
    stat_o.div_last  = (cnt_q == DIV_LAST);
    stat_o.sh_zero   = (sh_q == '0);
    stat_o.sh_lsb    = sh_q[0];
    stat_o.mul_done  = (mb_q == '0);
    stat_o.loop_exit = (e_q == pm1_q) || (x_q == WORD_ONE) || (x_q == pm1_q);
    stat_o.pass      = (x_q == pm1_q) || e_q[0];
  end

endmodule
`default_nettype wire

// ----- rtl/mr_ctrl.sv -----
// Controller: sequences one round and holds the output word register.
`timescale 1ns / 1ps
`default_nettype none
module mr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      logic             probably_prime_o,
  output      mr_pkg::mr_ctrl_t ctrl_o,
  input  wire mr_pkg::mr_stat_t stat_i
);
  import mr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ODD, S_DIV, S_WIT, S_POW, S_MR, S_POW_B, S_MB,
    S_LOOP, S_SQ, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   verdict_q, verdict_d;
  logic   out_valid_q, out_valid_d;
  logic   out_data_q, out_data_d;
  logic   can_emit;

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign probably_prime_o = out_data_q;
  assign can_emit         = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ctrl_o.cmd  = CMD_NONE;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        ctrl_o.cmd = CMD_LOAD;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.reject) begin
          verdict_d = 1'b0;
          state_d   = S_DONE;
        end else begin
          state_d = S_ODD;
        end
      end
      S_ODD: begin
        if (stat_i.s_odd) state_d = S_DIV;
        else ctrl_o.cmd = CMD_ODD_STEP;
      end
      S_DIV: begin
        ctrl_o.cmd = CMD_DIV_STEP;
        if (stat_i.div_last) state_d = S_WIT;
      end
      S_WIT: begin
        ctrl_o.cmd = CMD_WIT;
        state_d    = S_POW;
      end
      S_POW: begin
        priority if (stat_i.sh_zero) begin
          state_d = S_LOOP;
        end else if (stat_i.sh_lsb) begin
          ctrl_o.cmd = CMD_MUL_RES;
          state_d    = S_MR;
        end else begin
          ctrl_o.cmd = CMD_MUL_BASE;
          state_d    = S_MB;
        end
      end
      S_MR: begin
        if (stat_i.mul_done) begin
          ctrl_o.cmd = CMD_RES_WB;
          state_d    = S_POW_B;
        end else ctrl_o.cmd = CMD_MUL_STEP;
      end
      S_POW_B: begin
        ctrl_o.cmd = CMD_MUL_BASE;
        state_d    = S_MB;
      end
      S_MB: begin
        if (stat_i.mul_done) begin
          ctrl_o.cmd = CMD_BASE_WB;
          state_d    = S_POW;
        end else ctrl_o.cmd = CMD_MUL_STEP;
      end
      S_LOOP: begin
        if (stat_i.loop_exit) begin
          verdict_d = stat_i.pass;
          state_d   = S_DONE;
        end else begin
          ctrl_o.cmd = CMD_MUL_SQ;
          state_d    = S_SQ;
        end
      end
      S_SQ: begin
        if (stat_i.mul_done) begin
          ctrl_o.cmd = CMD_SQ_WB;
          state_d    = S_LOOP;
        end else ctrl_o.cmd = CMD_MUL_STEP;
      end
      S_DONE: if (can_emit) begin
        out_valid_d = 1'b1;
        out_data_d  = verdict_q;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      verdict_q   <= 1'b0;
      out_data_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      verdict_q   <= verdict_d;
      out_data_q  <= out_data_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/miller_rabin_round.sv -----
// Top level of the single-round Miller-Rabin primality tester.
`timescale 1ns / 1ps
`default_nettype none
// One Miller-Rabin round per word: the low NUM_BITS bits of candidate_i are
// read as a signed number p; negative, 0, 1 and even values other than 2 are
// rejected by the check state. Otherwise p-1 is stripped of its
// trailing zeros (one bit a cycle), the witness (random_value_i mod (p-1))+1
// is formed by a 32-step restoring divider, a^s mod p is computed by
// square-and-multiply, and x is squared until it hits 1 or p-1 or the
// exponent reaches p-1. Every modular product runs on one shared
// shift-and-add multiplier that retires one multiplier bit a cycle; a
// product is a start, at most 63 steps since the operands stay below
// p < 2^63, and a write-back. The exponent bits of s and the squarings
// share the 63 bits of p-1, so the worst case is p = 2^63-1; small
// candidates finish far sooner. One word is worked on at a time:
// in_stall_o is high from acceptance until the verdict moves to the output
// register, which then holds the result until taken while a new word is
// accepted. Multiple rounds are run by the caller, ANDing the verdicts.
module miller_rabin_round (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic signed [63:0]          candidate_i,
  input  wire logic [31:0]                 random_value_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic                        probably_prime_o
);
  import mr_pkg::*;

  mr_ctrl_t ctrl;
  mr_stat_t stat;

  // Bits above NUM_BITS are ignored.
  mr_datapath u_dp (
    .clk_i  (clk_i),
    .cand_i (candidate_i[NUM_BITS-1:0]),
    .rnd_i  (random_value_i[RND_W-1:0]),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  mr_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .probably_prime_o (probably_prime_o),
    .ctrl_o           (ctrl),
    .stat_i           (stat)
  );

endmodule
`default_nettype wire

// ----- rtl/mr_checker.sv -----
// Port-level checker for the Miller-Rabin round, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic probably_prime_o
);

  // A held result stays put until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(probably_prime_o))
    else $error("output word changed while stalled");

  // One word at a time: acceptance makes the block busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after accepting a word");

  // A new verdict only appears at the end of a busy period.
  a_verdict_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o) && !in_stall_o)
    else $error("verdict without work");

endmodule

bind miller_rabin_round mr_checker u_mr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .probably_prime_o (probably_prime_o)
);
`default_nettype wire
